// ===== hw/rtl/itda_pkg.sv =====
// shared constants and types for the integer to decimal text block
package itda_pkg;

  // width of the signed input word
  localparam int VALUE_BITS = 32;

  // decimal digits needed for any magnitude of VALUE_BITS bits
  localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_BITS   = NUM_DIGITS * 4;
  localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // shift-add-3 conversion takes this many magnitude bits per cycle
  localparam int STEP_BITS  = 4;
  localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS   = STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // classified word: sign and unsigned magnitude
  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } entry_t;

  // converted word: sign and packed bcd digits, digit 0 least significant
  typedef struct packed {
    logic                neg;
    logic [BCD_BITS-1:0] bcd;
  } conv_t;

  // converter control
  typedef enum logic [2:0] {
    CONV_IDLE = 3'b001,
    CONV_RUN  = 3'b010,
    CONV_DONE = 3'b100
  } conv_state_e;

endpackage

// ===== hw/rtl/itda_front.sv =====
// front end: takes a word and splits it into sign and magnitude
module itda_front (
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic [itda_pkg::VALUE_BITS-1:0] value_i,
  output logic                            wr_en_o,
  output itda_pkg::entry_t                entry_o
);
  import itda_pkg::*;

  // accept when the queue has room
  assign wr_en_o = push_i & ~full_i;

  // sign from the top bit, magnitude as unsigned two's complement negation
  always_comb begin
    entry_o.neg = value_i[VALUE_BITS-1];
    entry_o.mag = entry_o.neg ? (~value_i + VALUE_BITS'(1)) : value_i;
  end

endmodule

// ===== hw/rtl/itda_fifo.sv =====
// short queue of classified words between front and back
module itda_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  itda_pkg::entry_t wr_data_i,
  input  logic             rd_en_i,
  output itda_pkg::entry_t rd_data_o,
  output logic             full_o,
  output logic             empty_o
);
  import itda_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and count update with explicit wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/itda_convert.sv =====
// back end converter: binary magnitude to bcd by shift-add-3, four bits a cycle
module itda_convert (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  itda_pkg::entry_t entry_i,
  output logic             rd_en_o,
  output logic             done_o,
  output itda_pkg::conv_t  result_o,
  input  logic             take_i
);
  import itda_pkg::*;

  conv_state_e           state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [PAD_BITS-1:0]   sh_q, sh_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [PAD_BITS-1:0]   sh_w;
  logic [BCD_BITS-1:0]   bcd_w;

  assign rd_en_o      = (state_q == CONV_IDLE) & ~empty_i;
  assign done_o       = (state_q == CONV_DONE);
  assign result_o.neg = neg_q;
  assign result_o.bcd = bcd_q;

  // four dependent adjust-and-shift steps
  always_comb begin
    bcd_w = bcd_q;
    sh_w  = sh_q;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_w[d*4 +: 4] >= 4'd5) begin
          bcd_w[d*4 +: 4] = bcd_w[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_w, sh_w} = {bcd_w[BCD_BITS-2:0], sh_w, 1'b0};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    unique case (state_q)
      CONV_IDLE: begin
        if (!empty_i) begin
          sh_d    = PAD_BITS'(entry_i.mag);
          bcd_d   = '0;
          neg_d   = entry_i.neg;
          cnt_d   = '0;
          state_d = CONV_RUN;
        end
      end
      CONV_RUN: begin
        sh_d  = sh_w;
        bcd_d = bcd_w;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(STEPS - 1)) begin
          state_d = CONV_DONE;
        end
      end
      CONV_DONE: begin
        if (take_i) begin
          state_d = CONV_IDLE;
        end
      end
      default: state_d = CONV_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule

// ===== hw/rtl/itda_emit.sv =====
// back end emitter: sends sign and digits out one word per pop
module itda_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            done_i,
  input  itda_pkg::conv_t result_i,
  output logic            take_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [6:0]      character_o,
  output logic            last_o
);
  import itda_pkg::*;

  logic                 active_q, active_d;
  logic                 neg_q, neg_d;
  logic [DIG_IDX_W-1:0] idx_q, idx_d;
  logic [BCD_BITS-1:0]  bcd_q, bcd_d;
  logic [DIG_IDX_W-1:0] lead_w;
  logic [3:0]           digit_w;
  logic                 do_pop;

  // index of the leading nonzero digit, zero when all digits are zero
  always_comb begin
    lead_w = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (result_i.bcd[d*4 +: 4] != 4'd0) begin
        lead_w = DIG_IDX_W'(d);
      end
    end
  end

  // current output word
  assign digit_w     = bcd_q[idx_q*4 +: 4];
  assign empty_o     = ~active_q;
  assign character_o = neg_q ? CHAR_MINUS : (CHAR_ZERO + {3'b000, digit_w});
  assign last_o      = ~neg_q & (idx_q == '0);
  assign do_pop      = pop_i & active_q;
  assign take_o      = done_i & (~active_q | (do_pop & last_o));

  // walk sign, then digits from the top down
  always_comb begin
    active_d = active_q;
    neg_d    = neg_q;
    idx_d    = idx_q;
    bcd_d    = bcd_q;
    if (do_pop) begin
      if (neg_q) begin
        neg_d = 1'b0;
      end else if (idx_q == '0) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
    if (take_o) begin
      active_d = 1'b1;
      neg_d    = result_i.neg;
      idx_d    = lead_w;
      bcd_d    = result_i.bcd;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      neg_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      neg_q    <= neg_d;
      idx_q    <= idx_d;
    end
  end

  // digit buffer
  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

endmodule

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// top level: signed integer to decimal ascii characters
//
//   channel  direction  handshake      payload
//   input    in         push_i/full_o  value_i (32 bit signed)
//   result   out        pop_i/empty_o  character_o (7 bit), last_o
//
// a word is written into the queue, loaded into the converter, converted in the
// shift-add-3 loop (four magnitude bits per cycle) and handed off to the emitter.
// conversion of the next word overlaps the output of the current one.
// reset clears the queue, the converter and the emitter; pop held low stalls
// only the emitter, then the converter, then the queue, and finally full_o.
module int_to_decimal_ascii (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [itda_pkg::VALUE_BITS-1:0] value_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [6:0]                      character_o,
  output logic                            last_o
);
  import itda_pkg::*;

  logic   wr_en;
  entry_t wr_entry;
  logic   rd_en;
  entry_t rd_entry;
  logic   fifo_empty;
  logic   conv_done;
  conv_t  conv_result;
  logic   take;

  // sign and magnitude split
  itda_front u_front (
    .push_i  (push_i),
    .full_i  (full_o),
    .value_i (value_i),
    .wr_en_o (wr_en),
    .entry_o (wr_entry)
  );

  // decoupling queue
  itda_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_entry),
    .full_o    (full_o),
    .empty_o   (fifo_empty)
  );

  // binary to bcd
  itda_convert u_convert (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (fifo_empty),
    .entry_i  (rd_entry),
    .rd_en_o  (rd_en),
    .done_o   (conv_done),
    .result_o (conv_result),
    .take_i   (take)
  );

  // character output
  itda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (conv_done),
    .result_i    (conv_result),
    .take_o      (take),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
